FILE: rtl/core/svg_pkg.sv
// ----------------------------------------------------------------------------
// svg_pkg
// shared types and constants of the sphere vertex generator
// ----------------------------------------------------------------------------
package svg_pkg;

   // divider lanes: polar step, azimuth step, reversed polar step
   localparam int NUM_LANES = 3;
   localparam int LANE_ROW  = 0;
   localparam int LANE_COL  = 1;
   localparam int LANE_REV  = 2;

   // quotient of n * 65536 / s with n <= s, at most 65536
   localparam int QUOT_W = 17;

   typedef logic [NUM_LANES-1:0][7:0]        div_num_type;
   typedef logic [NUM_LANES-1:0][QUOT_W-1:0] div_quot_type;

   // configuration register map
   typedef enum logic [2:0] {
      CSR_RADIUS       = 3'd0,
      CSR_SLICES       = 3'd1,
      CSR_FIRST_RED    = 3'd2,
      CSR_FIRST_GREEN  = 3'd3,
      CSR_FIRST_BLUE   = 3'd4,
      CSR_SECOND_RED   = 3'd5,
      CSR_SECOND_GREEN = 3'd6,
      CSR_SECOND_BLUE  = 3'd7
   } csr_index_type;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

FILE: rtl/core/sphere_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// sphere_vertex_generator_core
// uv sphere vertex generator: grid point in, position, texture and color out
// ----------------------------------------------------------------------------
//
//   channel   ports                       handshake
//   -------   -------------------------   ---------------------------------
//   request   req_row_index, req_column_  word taken when start && !busy
//             index
//   response  rsp_pos_*, rsp_tex_*,       word valid for one cycle on
//             rsp_color_*                 rsp_strobe, no back-pressure
//   csr       csr_index, csr_wdata        write when csr_write is high
//
// one word per cycle; from accept to rsp_strobe a word passes through the
// index clamp stage, the three divider stages, the registered rom read,
// the trig product stage and the radius product stage
// busy stays low: the pipeline never stalls since the receiver cannot stall
// synchronous reset clears the valid bits and loads the csr defaults
//
module sphere_vertex_generator_core #(
   parameter int MAX_SLICES      = 255,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_row_index,
   input  logic [7:0]         req_column_index,
   // response
   output logic               rsp_strobe,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [7:0]         rsp_color_red,
   output logic [7:0]         rsp_color_green,
   output logic [7:0]         rsp_color_blue,
   output logic [7:0]         rsp_color_alpha,
   // csr
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import svg_pkg::*;

   localparam int         TB      = SINE_TABLE_BITS;
   localparam int         AW      = TB + 1;
   localparam logic [AW-1:0] TABLE_TOP = AW'(1 << TB);
   localparam logic [7:0] SMAX    = 8'(MAX_SLICES);
   localparam int         STAGES  = 7;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [15:0] radius_ff;
   logic [7:0]  slices_ff;
   logic [7:0]  first_red_ff, first_green_ff, first_blue_ff;
   logic [7:0]  second_red_ff, second_green_ff, second_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff       <= 16'd256;
         slices_ff       <= 8'd16;
         first_red_ff    <= 8'd255;
         first_green_ff  <= 8'd255;
         first_blue_ff   <= 8'd255;
         second_red_ff   <= 8'd0;
         second_green_ff <= 8'd0;
         second_blue_ff  <= 8'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RADIUS:       radius_ff       <= csr_wdata;
            CSR_SLICES:       slices_ff       <= csr_wdata[7:0];
            CSR_FIRST_RED:    first_red_ff    <= csr_wdata[7:0];
            CSR_FIRST_GREEN:  first_green_ff  <= csr_wdata[7:0];
            CSR_FIRST_BLUE:   first_blue_ff   <= csr_wdata[7:0];
            CSR_SECOND_RED:   second_red_ff   <= csr_wdata[7:0];
            CSR_SECOND_GREEN: second_green_ff <= csr_wdata[7:0];
            CSR_SECOND_BLUE:  second_blue_ff  <= csr_wdata[7:0];
         endcase
      end
   end

   // effective slice count: zero counts as one, capped at the maximum
   logic [7:0] slices_eff;
   always_comb begin
      priority if (slices_ff == 8'd0) begin
         slices_eff = 8'd1;
      end else if (slices_ff > SMAX) begin
         slices_eff = SMAX;
      end else begin
         slices_eff = slices_ff;
      end
   end

   // radius as a signed multiplier operand
   logic signed [16:0] radius_s;
   assign radius_s = signed'({1'b0, radius_ff});

   // ------------------------------------------------------------------
   // valid bits, one per stage
   // ------------------------------------------------------------------
   logic              req_accept;
   logic [STAGES-1:0] valid_ff, valid_in;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;
   assign valid_in   = {valid_ff[STAGES-2:0], req_accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: clamp the indexes to the slice count
   // ------------------------------------------------------------------
   logic [7:0]  row_clamp, col_clamp;
   div_num_type p1_num_ff, p1_num_in;
   logic [3:0]  odd_ff, odd_in;    // column parity through stages 1 to 4

   always_comb begin
      row_clamp = (req_row_index > slices_eff) ? slices_eff : req_row_index;
      col_clamp = (req_column_index > slices_eff) ? slices_eff : req_column_index;
      p1_num_in[LANE_ROW] = row_clamp;
      p1_num_in[LANE_COL] = col_clamp;
      p1_num_in[LANE_REV] = slices_eff - row_clamp;
      odd_in = {odd_ff[2:0], col_clamp[0]};
   end

   always_ff @(posedge clock) begin
      p1_num_ff <= p1_num_in;
      odd_ff    <= odd_in;
   end

   // ------------------------------------------------------------------
   // stages 2 to 4: turn fractions n * 65536 / slices
   // ------------------------------------------------------------------
   div_quot_type quot;

   svg_div_pipe u_div (
      .clock   (clock),
      .divisor (slices_eff),
      .num     (p1_num_ff),
      .quot    (quot)
   );

   // ------------------------------------------------------------------
   // stage 5: rom addresses from the phases, registered rom read
   // ------------------------------------------------------------------
   function automatic logic [AW-1:0] rom_addr(input logic [1:0] quad,
                                              input logic [TB-1:0] idx);
      // odd quadrants run the quarter wave backward
      if (quad[0]) begin
         return TABLE_TOP - {1'b0, idx};
      end
      return {1'b0, idx};
   endfunction

   logic [15:0]   phase_row, phase_col;
   logic [1:0]    quad_si, quad_ci, quad_sj, quad_cj;
   logic [TB-1:0] idx_row, idx_col;
   logic [AW-1:0] addr_si, addr_ci, addr_sj, addr_cj;

   always_comb begin
      // polar phase is half the turn fraction
      phase_row = quot[LANE_ROW][16:1];
      phase_col = quot[LANE_COL][15:0];    // a full turn wraps to zero
      quad_si   = phase_row[15:14];
      quad_ci   = phase_row[15:14] + 2'd1; // cosine is a quarter turn ahead
      quad_sj   = phase_col[15:14];
      quad_cj   = phase_col[15:14] + 2'd1;
      idx_row   = phase_row[13 -: TB];
      idx_col   = phase_col[13 -: TB];
      addr_si   = rom_addr(quad_si, idx_row);
      addr_ci   = rom_addr(quad_ci, idx_row);
      addr_sj   = rom_addr(quad_sj, idx_col);
      addr_cj   = rom_addr(quad_cj, idx_col);
   end

   logic [14:0] mag_si, mag_ci, mag_sj, mag_cj;

   svg_sine_rom #(
      .TABLE_BITS (SINE_TABLE_BITS)
   ) u_rom_row (
      .clock  (clock),
      .addr_a (addr_si),
      .addr_b (addr_ci),
      .data_a (mag_si),
      .data_b (mag_ci)
   );

   svg_sine_rom #(
      .TABLE_BITS (SINE_TABLE_BITS)
   ) u_rom_col (
      .clock  (clock),
      .addr_a (addr_sj),
      .addr_b (addr_cj),
      .data_a (mag_sj),
      .data_b (mag_cj)
   );

   // sign flags in order si, ci, sj, cj: negative in the lower half turn
   logic [3:0]  p5_neg_ff;
   logic [16:0] p5_tex_u_ff, p5_tex_v_ff;
   logic        p5_odd_ff;

   always_ff @(posedge clock) begin
      p5_neg_ff   <= {quad_si[1], quad_ci[1], quad_sj[1], quad_cj[1]};
      p5_tex_u_ff <= quot[LANE_COL];
      p5_tex_v_ff <= quot[LANE_REV];
      p5_odd_ff   <= odd_ff[3];
   end

   // ------------------------------------------------------------------
   // stage 6: signed trig values, the radius cosine product and the trig products
   // ------------------------------------------------------------------
   logic signed [15:0] sin_i, cos_i, sin_j, cos_j;
   logic signed [31:0] p6_ss_ff, p6_ss_in;
   logic signed [31:0] p6_sc_ff, p6_sc_in;
   logic signed [32:0] p6_z_ff, p6_z_in;
   logic [16:0]        p6_tex_u_ff, p6_tex_v_ff;
   logic               p6_odd_ff;

   always_comb begin
      sin_i = p5_neg_ff[3] ? -signed'({1'b0, mag_si}) : signed'({1'b0, mag_si});
      cos_i = p5_neg_ff[2] ? -signed'({1'b0, mag_ci}) : signed'({1'b0, mag_ci});
      sin_j = p5_neg_ff[1] ? -signed'({1'b0, mag_sj}) : signed'({1'b0, mag_sj});
      cos_j = p5_neg_ff[0] ? -signed'({1'b0, mag_cj}) : signed'({1'b0, mag_cj});
      p6_ss_in = sin_i * sin_j;
      p6_sc_in = sin_i * cos_j;
      p6_z_in  = radius_s * cos_i;
   end

   always_ff @(posedge clock) begin
      p6_ss_ff    <= p6_ss_in;
      p6_sc_ff    <= p6_sc_in;
      p6_z_ff     <= p6_z_in;
      p6_tex_u_ff <= p5_tex_u_ff;
      p6_tex_v_ff <= p5_tex_v_ff;
      p6_odd_ff   <= p5_odd_ff;
   end

   // ------------------------------------------------------------------
   // stage 7: radius products, floor shifts, stripe color, output word
   // ------------------------------------------------------------------
   logic signed [48:0] prod_x, prod_y;
   logic signed [16:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [16:0]        tex_u_ff, tex_v_ff;
   logic [7:0]         red_ff, green_ff, blue_ff;

   always_comb begin
      prod_x = radius_s * p6_ss_ff;
      prod_y = radius_s * p6_sc_ff;
   end

   always_ff @(posedge clock) begin
      // bit selects of the two's complement products give the floor
      pos_x_ff <= prod_x[46:30];
      pos_y_ff <= prod_y[46:30];
      pos_z_ff <= p6_z_ff[31:15];
      tex_u_ff <= p6_tex_u_ff;
      tex_v_ff <= p6_tex_v_ff;
      red_ff   <= p6_odd_ff ? second_red_ff   : first_red_ff;
      green_ff <= p6_odd_ff ? second_green_ff : first_green_ff;
      blue_ff  <= p6_odd_ff ? second_blue_ff  : first_blue_ff;
   end

   assign rsp_strobe      = valid_ff[STAGES-1];
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_pos_z       = pos_z_ff;
   assign rsp_tex_u       = tex_u_ff;
   assign rsp_tex_v       = tex_v_ff;
   assign rsp_color_red   = red_ff;
   assign rsp_color_green = green_ff;
   assign rsp_color_blue  = blue_ff;
   assign rsp_color_alpha = ALPHA_OPAQUE;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------

   // every accepted word is followed by its response word on rsp_strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##7 rsp_strobe)
      else $error("response word missing after accept");

   // no response word without a matching accept before it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept, 7))
      else $error("response word without a matching accept");

   // turn fractions never exceed one full turn
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_tex_u <= 17'h10000) && (rsp_tex_v <= 17'h10000))
      else $error("texture coordinate beyond one");

endmodule

FILE: rtl/core/svg_div_pipe.sv
// ----------------------------------------------------------------------------
// svg_div_pipe
// three-stage restoring divider, three lanes: floor(n * 65536 / s), n <= s
// ----------------------------------------------------------------------------
module svg_div_pipe (
   input  logic                 clock,
   input  logic [7:0]           divisor,
   input  svg_pkg::div_num_type num,
   output svg_pkg::div_quot_type quot
);
   import svg_pkg::*;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [8:0] div_step(input logic [8:0] t, input logic [7:0] d);
      logic [8:0] diff;
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         return {1'b1, diff[7:0]};
      end
      return {1'b0, t[7:0]};
   endfunction

   logic [NUM_LANES-1:0][7:0]  a_rem_ff, a_rem_in;
   logic [NUM_LANES-1:0][5:0]  a_q_ff, a_q_in;
   logic [NUM_LANES-1:0][7:0]  b_rem_ff, b_rem_in;
   logic [NUM_LANES-1:0][11:0] b_q_ff, b_q_in;
   logic [NUM_LANES-1:0][QUOT_W-1:0] c_q_ff, c_q_in;

   // stage a: integer bit plus five fraction bits
   always_comb begin
      logic [7:0] r;
      logic [8:0] st;
      logic [5:0] q;
      for (int l = 0; l < NUM_LANES; l++) begin
         st = div_step({1'b0, num[l]}, divisor);
         q  = '0;
         q[5] = st[8];
         r  = st[7:0];
         for (int k = 4; k >= 0; k--) begin
            st   = div_step({r, 1'b0}, divisor);
            q[k] = st[8];
            r    = st[7:0];
         end
         a_q_in[l]   = q;
         a_rem_in[l] = r;
      end
   end

   // stage b: six more bits
   always_comb begin
      logic [7:0]  r;
      logic [8:0]  st;
      logic [11:0] q;
      for (int l = 0; l < NUM_LANES; l++) begin
         q = {a_q_ff[l], 6'b0};
         r = a_rem_ff[l];
         for (int k = 5; k >= 0; k--) begin
            st   = div_step({r, 1'b0}, divisor);
            q[k] = st[8];
            r    = st[7:0];
         end
         b_q_in[l]   = q;
         b_rem_in[l] = r;
      end
   end

   // stage c: last five bits
   always_comb begin
      logic [7:0]        r;
      logic [8:0]        st;
      logic [QUOT_W-1:0] q;
      for (int l = 0; l < NUM_LANES; l++) begin
         q = {b_q_ff[l], 5'b0};
         r = b_rem_ff[l];
         for (int k = 4; k >= 0; k--) begin
            st   = div_step({r, 1'b0}, divisor);
            q[k] = st[8];
            r    = st[7:0];
         end
         c_q_in[l] = q;
      end
   end

   always_ff @(posedge clock) begin
      a_rem_ff <= a_rem_in;
      a_q_ff   <= a_q_in;
      b_rem_ff <= b_rem_in;
      b_q_ff   <= b_q_in;
      c_q_ff   <= c_q_in;
   end

   assign quot = c_q_ff;

endmodule

FILE: rtl/core/svg_sine_rom.sv
// ----------------------------------------------------------------------------
// svg_sine_rom
// quarter-wave sine rom, round(32767 * sin), two registered read ports
// ----------------------------------------------------------------------------
module svg_sine_rom #(
   parameter int TABLE_BITS = 10
) (
   input  logic                clock,
   input  logic [TABLE_BITS:0] addr_a,
   input  logic [TABLE_BITS:0] addr_b,
   output logic [14:0]         data_a,
   output logic [14:0]         data_b
);

   localparam int TABLE_N = 1 << TABLE_BITS;

   typedef logic [14:0] rom_type [TABLE_N+1];

   function automatic rom_type build_rom();
      rom_type t;
      real     a;
      for (int k = 0; k <= TABLE_N; k++) begin
         a    = 1.5707963267948966 * k / TABLE_N;
         t[k] = 15'($rtoi(32767.0 * $sin(a) + 0.5));
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [14:0] data_a_ff;
   logic [14:0] data_b_ff;

   always_ff @(posedge clock) begin
      data_a_ff <= SINE_ROM[addr_a];
      data_b_ff <= SINE_ROM[addr_b];
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

FILE: dv/sphere_vertex_generator_core_test.sv
// ----------------------------------------------------------------------------
// sphere_vertex_generator_core_test
// self-checking bench for the uv sphere vertex generator core
//
// a directed plan covers the poles, the equator, the full-turn wrap, index
// saturation and the slice and radius extremes, with hand-worked vertices
// where they are obvious; then about 1300 random grid points go through
// under thirteen random register setups and three sender idle levels.
// every response word is compared field by field against its hand-worked vertex
// or a local fixed point model built from its own quarter-wave sine table.
// ----------------------------------------------------------------------------
module sphere_vertex_generator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import svg_pkg::*;

   localparam int          TABLE_BITS     = 10;
   localparam int          TABLE_TOP      = 1 << TABLE_BITS;
   localparam int          PIPE_LATENCY   = 7;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          RANDOM_CHUNKS  = 13;
   localparam int          CHUNK_WORDS    = 100;
   localparam logic [63:0] HALF_PI_Q60    = 64'h1921FB54442D1847;

   // one vertex as it leaves the response port
   typedef struct packed {
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [16:0] pos_z;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
   } vertex_type;

   // directed plan rows: a grid point checked by the model, a grid point
   // with a hand-worked vertex, or a register write
   typedef enum logic [1:0] {ROW_WORD, ROW_TYPED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [7:0]    row;
      logic [7:0]    col;
      csr_index_type index;
      logic [15:0]   wdata;
      vertex_type    want;
   } plan_row_type;

   localparam vertex_type NO_VERTEX = '0;

   localparam plan_row_type DIRECTED_PLAN [34] = '{
      // reset setup: radius 1.0, 16 slices, white on even columns, black on odd
      // north pole
      '{ROW_TYPED, 8'd0, 8'd0, CSR_RADIUS, 16'h0000,
        '{17'sd0, 17'sd0, 17'sd255, 17'd0, 17'd65536, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      // south pole
      '{ROW_TYPED, 8'd16, 8'd0, CSR_RADIUS, 16'h0000,
        '{17'sd0, 17'sd0, -17'sd256, 17'd0, 17'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      // equator at zero, a quarter and half a turn
      '{ROW_TYPED, 8'd8, 8'd0, CSR_RADIUS, 16'h0000,
        '{17'sd0, 17'sd255, 17'sd0, 17'd0, 17'd32768, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      '{ROW_TYPED, 8'd8, 8'd4, CSR_RADIUS, 16'h0000,
        '{17'sd255, 17'sd0, 17'sd0, 17'd16384, 17'd32768, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      '{ROW_TYPED, 8'd8, 8'd8, CSR_RADIUS, 16'h0000,
        '{17'sd0, -17'sd256, 17'sd0, 17'd32768, 17'd32768, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      // full turn wraps the azimuth phase back to zero
      '{ROW_TYPED, 8'd8, 8'd16, CSR_RADIUS, 16'h0000,
        '{17'sd0, 17'sd255, 17'sd0, 17'd65536, 17'd32768, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      // both indexes saturate to slices
      '{ROW_TYPED, 8'd255, 8'd255, CSR_RADIUS, 16'h0000,
        '{17'sd0, 17'sd0, -17'sd256, 17'd65536, 17'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      '{ROW_WORD, 8'd8, 8'd1, CSR_RADIUS, 16'h0000, NO_VERTEX},
      '{ROW_WORD, 8'd4, 8'd12, CSR_RADIUS, 16'h0000, NO_VERTEX},
      '{ROW_WORD, 8'd200, 8'd3, CSR_RADIUS, 16'h0000, NO_VERTEX},
      // largest radius and slice count, junk in the unused upper byte
      '{ROW_CSR, 8'd0, 8'd0, CSR_RADIUS, 16'hFFFF, NO_VERTEX},
      '{ROW_CSR, 8'd0, 8'd0, CSR_SLICES, 16'hA5FF, NO_VERTEX},
      '{ROW_CSR, 8'd0, 8'd0, CSR_FIRST_RED, 16'hFF12, NO_VERTEX},
      '{ROW_CSR, 8'd0, 8'd0, CSR_FIRST_GREEN, 16'h0034, NO_VERTEX},
      '{ROW_CSR, 8'd0, 8'd0, CSR_FIRST_BLUE, 16'hC356, NO_VERTEX},
      '{ROW_CSR, 8'd0, 8'd0, CSR_SECOND_RED, 16'h3CA5, NO_VERTEX},
      '{ROW_CSR, 8'd0, 8'd0, CSR_SECOND_GREEN, 16'h005A, NO_VERTEX},
      '{ROW_CSR, 8'd0, 8'd0, CSR_SECOND_BLUE, 16'hFFC3, NO_VERTEX},
      '{ROW_TYPED, 8'd0, 8'd0, CSR_RADIUS, 16'h0000,
        '{17'sd0, 17'sd0, 17'sd65533, 17'd0, 17'd65536, 8'h12, 8'h34, 8'h56, 8'hFF}},
      '{ROW_TYPED, 8'd255, 8'd255, CSR_RADIUS, 16'h0000,
        '{17'sd0, 17'sd0, -17'sd65534, 17'd65536, 17'd0, 8'hA5, 8'h5A, 8'hC3, 8'hFF}},
      '{ROW_WORD, 8'd1, 8'd1, CSR_RADIUS, 16'h0000, NO_VERTEX},
      '{ROW_WORD, 8'd127, 8'd128, CSR_RADIUS, 16'h0000, NO_VERTEX},
      '{ROW_WORD, 8'd128, 8'd127, CSR_RADIUS, 16'h0000, NO_VERTEX},
      '{ROW_WORD, 8'd254, 8'd253, CSR_RADIUS, 16'h0000, NO_VERTEX},
      '{ROW_WORD, 8'd64, 8'd191, CSR_RADIUS, 16'h0000, NO_VERTEX},
      // zero radius, zero slices behaves as one slice
      '{ROW_CSR, 8'd0, 8'd0, CSR_RADIUS, 16'h0000, NO_VERTEX},
      '{ROW_CSR, 8'd0, 8'd0, CSR_SLICES, 16'h5A00, NO_VERTEX},
      '{ROW_TYPED, 8'd0, 8'd0, CSR_RADIUS, 16'h0000,
        '{17'sd0, 17'sd0, 17'sd0, 17'd0, 17'd65536, 8'h12, 8'h34, 8'h56, 8'hFF}},
      '{ROW_TYPED, 8'd1, 8'd1, CSR_RADIUS, 16'h0000,
        '{17'sd0, 17'sd0, 17'sd0, 17'd65536, 17'd0, 8'hA5, 8'h5A, 8'hC3, 8'hFF}},
      '{ROW_WORD, 8'd9, 8'd200, CSR_RADIUS, 16'h0000, NO_VERTEX},
      // a single slice with half radius
      '{ROW_CSR, 8'd0, 8'd0, CSR_SLICES, 16'h0001, NO_VERTEX},
      '{ROW_CSR, 8'd0, 8'd0, CSR_RADIUS, 16'h8000, NO_VERTEX},
      '{ROW_WORD, 8'd0, 8'd1, CSR_RADIUS, 16'h0000, NO_VERTEX},
      '{ROW_WORD, 8'd1, 8'd0, CSR_RADIUS, 16'h0000, NO_VERTEX}
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [7:0]         req_row_index;
   logic [7:0]         req_column_index;
   logic               rsp_strobe;
   logic signed [16:0] rsp_pos_x;
   logic signed [16:0] rsp_pos_y;
   logic signed [16:0] rsp_pos_z;
   logic [16:0]        rsp_tex_u;
   logic [16:0]        rsp_tex_v;
   logic [7:0]         rsp_color_red;
   logic [7:0]         rsp_color_green;
   logic [7:0]         rsp_color_blue;
   logic [7:0]         rsp_color_alpha;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;

   // shadow of the register file, updated as the bench writes it
   logic [15:0] radius_q88;
   logic [7:0]  slice_count;
   logic [7:0]  even_color [3];
   logic [7:0]  odd_color [3];

   // quarter-wave table, round(32767*sin), same layout as the hardware rom, built by series
   int sine_quarter [0:TABLE_TOP];

   vertex_type pending_vertices [$];
   int         mismatches = 0;
   int         idle_percent;
   int         quiet_cycles;

   sphere_vertex_generator_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_color_red    (rsp_color_red),
      .rsp_color_green  (rsp_color_green),
      .rsp_color_blue   (rsp_color_blue),
      .rsp_color_alpha  (rsp_color_alpha),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // fixed point model
   // ------------------------------------------------------------------------

   // (a*b [+ half]) >> 60 on a 128-bit product, kept to 64 bits
   function automatic logic [63:0] q60_product(logic [63:0] a, logic [63:0] b,
                                               bit round_half);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      if (round_half)
         wide = wide + (128'd1 << 59);
      return wide[123:60];
   endfunction

   // taylor series of sin over the first quarter turn, fifteen terms
   function automatic void build_sine_quarter();
      logic [63:0] angle, angle_sq, term, series, scaled;
      for (int k = 0; k <= TABLE_TOP; k++) begin
         angle    = q60_product(HALF_PI_Q60, 64'(k) << (60 - TABLE_BITS), 1'b0);
         angle_sq = q60_product(angle, angle, 1'b1);
         term     = angle;
         series   = angle;
         for (int n = 1; n <= 14; n++) begin
            term = q60_product(term, angle_sq, 1'b1) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
               series = series - term;
            else
               series = series + term;
         end
         scaled = q60_product(series, 64'd32767, 1'b1);
         if (scaled > 64'd32767)
            scaled = 64'd32767;
         sine_quarter[k] = int'(scaled);
      end
   endfunction

   // quadrant from the top two phase bits, no interpolation
   function automatic int sine_at(logic [15:0] phase);
      int slot;
      int magnitude;
      slot      = int'(phase[13:14-TABLE_BITS]);
      magnitude = phase[14] ? sine_quarter[TABLE_TOP - slot] : sine_quarter[slot];
      return phase[15] ? -magnitude : magnitude;
   endfunction

   function automatic vertex_type compute_vertex(logic [7:0] row, logic [7:0] col);
      int          divs, polar, azim;
      logic [15:0] polar_phase, azim_phase;
      longint      sin_p, cos_p, sin_a, cos_a, rad;
      vertex_type  v;
      // zero slices acts as one; the 8-bit register cannot exceed the maximum
      divs  = (slice_count == 8'd0) ? 1 : int'(slice_count);
      polar = (int'(row) > divs) ? divs : int'(row);
      azim  = (int'(col) > divs) ? divs : int'(col);
      // a full turn of azimuth truncates to phase zero
      polar_phase = 16'((polar * 32768) / divs);
      azim_phase  = 16'((azim * 65536) / divs);
      sin_p = sine_at(polar_phase);
      cos_p = sine_at(polar_phase + 16'd16384);
      sin_a = sine_at(azim_phase);
      cos_a = sine_at(azim_phase + 16'd16384);
      rad   = longint'(radius_q88);
      v.pos_x = 17'((rad * sin_p * sin_a) >>> 30);
      v.pos_y = 17'((rad * sin_p * cos_a) >>> 30);
      v.pos_z = 17'((rad * cos_p) >>> 15);
      v.tex_u = 17'((azim * 65536) / divs);
      v.tex_v = 17'(((divs - polar) * 65536) / divs);
      v.red   = azim[0] ? odd_color[0] : even_color[0];
      v.green = azim[0] ? odd_color[1] : even_color[1];
      v.blue  = azim[0] ? odd_color[2] : even_color[2];
      v.alpha = 8'hFF;
      return v;
   endfunction

   // ------------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------------

   // back-to-back writes keep csr_write high; the next word lowers it
   task automatic write_register(csr_index_type index, logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_RADIUS:       radius_q88    = data;
         CSR_SLICES:       slice_count   = data[7:0];
         CSR_FIRST_RED:    even_color[0] = data[7:0];
         CSR_FIRST_GREEN:  even_color[1] = data[7:0];
         CSR_FIRST_BLUE:   even_color[2] = data[7:0];
         CSR_SECOND_RED:   odd_color[0]  = data[7:0];
         CSR_SECOND_GREEN: odd_color[1]  = data[7:0];
         CSR_SECOND_BLUE:  odd_color[2]  = data[7:0];
      endcase
   endtask

   // every word gives exactly one vertex, so an empty queue means idle
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_vertices.size() != 0)
         @(posedge clock);
   endtask

   // start stays high into the next word unless an idle cycle is drawn
   task automatic send_word(logic [7:0] row, logic [7:0] col, bit typed,
                            vertex_type want);
      csr_write        <= 1'b0;
      req_row_index    <= row;
      req_column_index <= col;
      start            <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      pending_vertices.push_back(typed ? want : compute_vertex(row, col));
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // new setup between chunks: extremes now and then, junk in unused bits
   task automatic load_random_setup();
      logic [15:0] radius_pick;
      logic [7:0]  slices_pick;
      case ($urandom_range(7))
         0:       radius_pick = 16'h0000;
         1:       radius_pick = 16'hFFFF;
         default: radius_pick = 16'($urandom_range(16'hFFFF));
      endcase
      case ($urandom_range(9))
         0:       slices_pick = 8'd0;
         1:       slices_pick = 8'd1;
         2:       slices_pick = 8'd255;
         3:       slices_pick = 8'($urandom_range(255));
         default: slices_pick = 8'($urandom_range(40, 2));
      endcase
      wait_for_drain();
      write_register(CSR_RADIUS, radius_pick);
      write_register(CSR_SLICES, {8'($urandom_range(255)), slices_pick});
      for (int n = int'(CSR_FIRST_RED); n <= int'(CSR_SECOND_BLUE); n++)
         write_register(csr_index_type'(n), 16'($urandom_range(16'hFFFF)));
   endtask

   initial begin
      int          divs;
      logic [7:0]  row, col;
      bit          after_write;
      build_sine_quarter();
      reset            = 1'b1;
      start            = 1'b0;
      req_row_index    = 8'd0;
      req_column_index = 8'd0;
      csr_write        = 1'b0;
      csr_index        = CSR_RADIUS;
      csr_wdata        = 16'd0;
      radius_q88       = 16'd256;
      slice_count      = 8'd16;
      even_color       = '{8'hFF, 8'hFF, 8'hFF};
      odd_color        = '{8'h00, 8'h00, 8'h00};
      idle_percent     = 20;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed plan
      after_write = 1'b0;
      foreach (DIRECTED_PLAN[n]) begin
         if (DIRECTED_PLAN[n].kind == ROW_CSR) begin
            if (!after_write)
               wait_for_drain();
            write_register(DIRECTED_PLAN[n].index, DIRECTED_PLAN[n].wdata);
         end else begin
            send_word(DIRECTED_PLAN[n].row, DIRECTED_PLAN[n].col,
                      DIRECTED_PLAN[n].kind == ROW_TYPED, DIRECTED_PLAN[n].want);
         end
         after_write = (DIRECTED_PLAN[n].kind == ROW_CSR);
      end

      // random grid points: light idling, heavy idling, then none
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         idle_percent = (chunk < 4) ? 36 : (chunk < 8) ? 74 : 0;
         load_random_setup();
         divs = (slice_count == 8'd0) ? 1 : int'(slice_count);
         for (int k = 0; k < CHUNK_WORDS; k++) begin
            // mostly in range, some indexes past slices to hit saturation
            if ($urandom_range(4) == 0) begin
               row = 8'($urandom_range(255));
               col = 8'($urandom_range(255));
            end else begin
               row = 8'($urandom_range(divs));
               col = 8'($urandom_range(divs));
            end
            send_word(row, col, 1'b0, NO_VERTEX);
            // hold off once until the pipeline is empty
            if (chunk == 1 && k == CHUNK_WORDS / 2)
               wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (3 * PIPE_LATENCY) @(posedge clock);
      if (mismatches == 0 && pending_vertices.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic check_field(string field, int want, int got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // response word is valid for exactly the cycle that rsp_strobe is high
   always @(posedge clock) begin : vertex_check
      vertex_type want;
      if (!reset && rsp_strobe) begin
         if (pending_vertices.size() == 0) begin
            $display("%0t: vertex word with none expected", $time);
            mismatches++;
         end else begin
            want = pending_vertices.pop_front();
            check_field("pos_x", want.pos_x, rsp_pos_x);
            check_field("pos_y", want.pos_y, rsp_pos_y);
            check_field("pos_z", want.pos_z, rsp_pos_z);
            check_field("tex_u", want.tex_u, rsp_tex_u);
            check_field("tex_v", want.tex_v, rsp_tex_v);
            check_field("color_red", want.red, rsp_color_red);
            check_field("color_green", want.green, rsp_color_green);
            check_field("color_blue", want.blue, rsp_color_blue);
            check_field("color_alpha", want.alpha, rsp_color_alpha);
         end
      end
   end

   // watchdog: a long stretch with no word moving on any port ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress, %0d vertices outstanding", $time,
                  pending_vertices.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

FILE: sim.f
rtl/core/svg_pkg.sv
rtl/core/svg_div_pipe.sv
rtl/core/svg_sine_rom.sv
rtl/core/sphere_vertex_generator_core.sv
dv/sphere_vertex_generator_core_test.sv
